@@ design/mino_pkg.sv @@
package mino_pkg;

   // statistics widths
   localparam int COUNT_BITS = 24;
   localparam int CNT_W      = COUNT_BITS + 1;
   localparam int SUM_W      = 43;
   localparam int SQ_W       = 64;

   // shift-add multiplier and restoring divider widths
   localparam int MUL_W      = 89;
   localparam int PLIER_W    = 43;
   localparam int DIV_W      = 105;
   localparam int DEN_W      = 43;
   localparam int DCNT_W     = 7;
   localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DIV_W);

   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(1) << COUNT_BITS;

   // configuration register indexes
   localparam logic [2:0] CSR_PIXEL_OFFSET = 3'd0;
   localparam logic [2:0] CSR_NORMAL_VALUE = 3'd1;
   localparam logic [2:0] CSR_ADD_CONST    = 3'd2;
   localparam logic [2:0] CSR_CUT_OUTSIDE  = 3'd3;
   localparam logic [2:0] CSR_BYTE_PIXELS  = 3'd4;

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_ACCUM = 2'd1,
      FUNC_FINAL = 2'd2,
      FUNC_XFORM = 2'd3
   } func_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_ACC_PREP,
      CMD_ACC_ADD,
      CMD_XPROD,
      CMD_OUT_XFORM,
      CMD_MUL_NSQ,
      CMD_MUL_MAG,
      CMD_DIV_VAR,
      CMD_DIV_AGAIN,
      CMD_SQRT,
      CMD_DIV_MEAN,
      CMD_MEAN_SAVE,
      CMD_MUL_SCALE,
      CMD_DIV_SCALE,
      CMD_SCALE_SAVE,
      CMD_OUT_STATS
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    latch;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     n_zero;
      logic     empty;
      logic     mul_done;
      logic     div_done;
      logic     sqrt_done;
   } dp_status_type;

endpackage

@@ design/mino_dpath.sv @@
module mino_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  mino_pkg::dp_cmd_type        ctl,
   output mino_pkg::dp_status_type     status,
   input  logic [1:0]                  req_func,
   input  logic [15:0]                 req_pixel_in,
   input  logic [7:0]                  req_mask_byte,
   input  logic                        csr_wr_en,
   input  logic [2:0]                  csr_index,
   input  logic [23:0]                 csr_wdata,
   output logic [15:0]                 rsp_pixel_out,
   output logic signed [25:0]          rsp_mean_out,
   output logic [24:0]                 rsp_sd_out,
   output logic [15:0]                 rsp_min_out,
   output logic [15:0]                 rsp_max_out,
   output logic [24:0]                 rsp_pixel_count,
   output logic                        rsp_empty_flag,
   output logic                        rsp_is_stats
);

   // configuration
   logic signed [16:0] offset_ff;
   logic [23:0]        normal_ff;
   logic [15:0]        add_const_ff;
   logic               cut_ff;
   logic               byte_ff;

   // latched item
   logic [1:0]  func_ff;
   logic [15:0] pix_ff;
   logic [7:0]  mask_ff;

   // statistics
   logic signed [mino_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [mino_pkg::SQ_W-1:0]         sumsq_ff, sumsq_in;
   logic [mino_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [15:0]                       min_ff, min_in, max_ff, max_in;
   logic [31:0]                       scale_ff, scale_in;

   // accumulate stage
   logic                      acc_en_ff, acc_en_in;
   logic [15:0]               accp_ff, accp_in;
   logic signed [17:0]        accv_ff, accv_in;
   logic [33:0]               accsq_ff, accsq_in;

   // transform product
   logic signed [50:0] prod_ff, prod_in;

   // multiplier
   logic [mino_pkg::MUL_W-1:0]   mul_acc_ff, mul_acc_in, mul_cand_ff, mul_cand_in;
   logic [mino_pkg::PLIER_W-1:0] mul_plier_ff, mul_plier_in;
   logic [mino_pkg::MUL_W-1:0]   hold_ff, hold_in;

   // divider
   logic [mino_pkg::DIV_W-1:0]  div_num_ff, div_num_in;
   logic [mino_pkg::DEN_W-1:0]  div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [mino_pkg::DCNT_W-1:0] div_cnt_ff, div_cnt_in;

   // square root
   logic [63:0] sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;

   // finalize results
   logic signed [25:0] mean_ff, mean_in;
   logic [24:0]        sd_ff, sd_in;

   // output register
   logic [15:0]        o_pix_ff, o_pix_in;
   logic signed [25:0] o_mean_ff, o_mean_in;
   logic [24:0]        o_sd_ff, o_sd_in;
   logic [15:0]        o_min_ff, o_min_in, o_max_ff, o_max_in;
   logic [24:0]        o_cnt_ff, o_cnt_in;
   logic               o_empty_ff, o_empty_in, o_stats_ff, o_stats_in;

   // helpers
   logic [15:0]                  pix_raw;
   logic signed [17:0]           pix_val;
   logic [16:0]                  pix_mag;
   logic [mino_pkg::SUM_W-1:0]   sum_mag;
   logic                         sum_neg;
   logic                         n_zero;
   logic                         empty;
   logic [mino_pkg::MUL_W-1:0]   var_diff;
   logic [mino_pkg::DEN_W:0]     rem_sh;
   logic                         rem_ge;
   logic [64:0]                  sq_try;
   logic signed [51:0]           xf_sum;
   logic signed [51:0]           xf_max;
   logic [15:0]                  xf_pix;

   always_comb begin
      pix_raw = byte_ff ? {8'h00, pix_ff[7:0]} : pix_ff;
      pix_val = $signed({2'b00, pix_raw}) + 18'(offset_ff);
      pix_mag = pix_val[17] ? 17'(-pix_val) : pix_val[16:0];
      sum_neg = sum_ff[mino_pkg::SUM_W-1];
      sum_mag = sum_neg ? -sum_ff : sum_ff;
      n_zero  = (count_ff == '0);
      empty   = n_zero || sum_neg || (sum_ff == '0);
      var_diff = (hold_ff >= mul_acc_ff) ? hold_ff - mul_acc_ff : '0;
      rem_sh  = {div_rem_ff, div_num_ff[mino_pkg::DIV_W-1]};
      rem_ge  = rem_sh >= {1'b0, div_den_ff};
      sq_try  = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};
      // floor shift, then offset by the constant
      if (cut_ff && (mask_ff == 8'h00)) begin
         xf_sum = $signed({36'd0, add_const_ff});
      end else begin
         xf_sum = 52'(prod_ff >>> 16) + $signed({36'd0, add_const_ff});
      end
      xf_max = byte_ff ? 52'sd255 : 52'sd65535;
      if (xf_sum < 0) begin
         xf_pix = 16'h0000;
      end else if (xf_sum > xf_max) begin
         xf_pix = xf_max[15:0];
      end else begin
         xf_pix = xf_sum[15:0];
      end
   end

   always_comb begin
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      scale_in     = scale_ff;
      acc_en_in    = acc_en_ff;
      accp_in      = accp_ff;
      accv_in      = accv_ff;
      accsq_in     = accsq_ff;
      prod_in      = prod_ff;
      hold_in      = hold_ff;
      mean_in      = mean_ff;
      sd_in        = sd_ff;
      o_pix_in     = o_pix_ff;
      o_mean_in    = o_mean_ff;
      o_sd_in      = o_sd_ff;
      o_min_in     = o_min_ff;
      o_max_in     = o_max_ff;
      o_cnt_in     = o_cnt_ff;
      o_empty_in   = o_empty_ff;
      o_stats_in   = o_stats_ff;

      // free-running units
      mul_acc_in   = mul_acc_ff;
      mul_cand_in  = mul_cand_ff;
      mul_plier_in = mul_plier_ff;
      if (mul_plier_ff != '0) begin
         if (mul_plier_ff[0]) mul_acc_in = mul_acc_ff + mul_cand_ff;
         mul_cand_in  = mul_cand_ff << 1;
         mul_plier_in = mul_plier_ff >> 1;
      end

      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      if (div_cnt_ff != '0) begin
         div_rem_in = rem_ge ? mino_pkg::DEN_W'(rem_sh - {1'b0, div_den_ff})
                             : rem_sh[mino_pkg::DEN_W-1:0];
         div_num_in = {div_num_ff[mino_pkg::DIV_W-2:0], rem_ge};
         div_cnt_in = div_cnt_ff - 1'b1;
      end

      sq_v_in   = sq_v_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      if (sq_bit_ff != '0) begin
         if ({1'b0, sq_v_ff} >= sq_try) begin
            sq_v_in   = sq_v_ff - sq_try[63:0];
            sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_in = sq_res_ff >> 1;
         end
         sq_bit_in = sq_bit_ff >> 2;
      end

      case (ctl.cmd)
         mino_pkg::CMD_CLEAR: begin
            sum_in   = '0;
            sumsq_in = '0;
            count_in = '0;
            min_in   = 16'hFFFF;
            max_in   = 16'h0000;
         end
         mino_pkg::CMD_ACC_PREP: begin
            acc_en_in = (mask_ff != 8'h00) && (count_ff < mino_pkg::COUNT_FULL);
            accp_in   = pix_raw;
            accv_in   = pix_val;
            accsq_in  = pix_mag * pix_mag;
         end
         mino_pkg::CMD_ACC_ADD: begin
            if (acc_en_ff) begin
               sum_in   = sum_ff + mino_pkg::SUM_W'(accv_ff);
               sumsq_in = sumsq_ff + mino_pkg::SQ_W'(accsq_ff);
               count_in = count_ff + 1'b1;
               if (accp_ff < min_ff) min_in = accp_ff;
               if (accp_ff > max_ff) max_in = accp_ff;
            end
         end
         mino_pkg::CMD_XPROD: begin
            prod_in = 51'(pix_val) * $signed({19'd0, scale_ff});
         end
         mino_pkg::CMD_OUT_XFORM: begin
            o_pix_in   = xf_pix;
            o_mean_in  = '0;
            o_sd_in    = '0;
            o_min_in   = '0;
            o_max_in   = '0;
            o_cnt_in   = '0;
            o_empty_in = 1'b0;
            o_stats_in = 1'b0;
         end
         mino_pkg::CMD_MUL_NSQ: begin
            mul_acc_in   = '0;
            mul_cand_in  = mino_pkg::MUL_W'(sumsq_ff);
            mul_plier_in = mino_pkg::PLIER_W'(count_ff);
         end
         mino_pkg::CMD_MUL_MAG: begin
            hold_in      = mul_acc_ff;
            mul_acc_in   = '0;
            mul_cand_in  = mino_pkg::MUL_W'(sum_mag);
            mul_plier_in = sum_mag;
         end
         mino_pkg::CMD_DIV_VAR: begin
            div_num_in = {var_diff, 16'h0000};
            div_rem_in = '0;
            div_den_in = mino_pkg::DEN_W'(count_ff);
            div_cnt_in = mino_pkg::DIV_STEPS;
         end
         mino_pkg::CMD_DIV_AGAIN: begin
            div_rem_in = '0;
            div_cnt_in = mino_pkg::DIV_STEPS;
         end
         mino_pkg::CMD_SQRT: begin
            sq_v_in   = (|div_num_ff[mino_pkg::DIV_W-1:64]) ? '1 : div_num_ff[63:0];
            sq_res_in = '0;
            sq_bit_in = 64'h4000_0000_0000_0000;
         end
         mino_pkg::CMD_DIV_MEAN: begin
            sd_in      = sq_res_ff[24:0];
            div_num_in = mino_pkg::DIV_W'({sum_mag, 8'h00})
                         + mino_pkg::DIV_W'(count_ff >> 1);
            div_rem_in = '0;
            div_den_in = mino_pkg::DEN_W'(count_ff);
            div_cnt_in = mino_pkg::DIV_STEPS;
         end
         mino_pkg::CMD_MEAN_SAVE: begin
            mean_in = sum_neg ? -$signed(div_num_ff[25:0]) : $signed(div_num_ff[25:0]);
         end
         mino_pkg::CMD_MUL_SCALE: begin
            mul_acc_in   = '0;
            mul_cand_in  = mino_pkg::MUL_W'({normal_ff, 8'h00});
            mul_plier_in = mino_pkg::PLIER_W'(count_ff);
         end
         mino_pkg::CMD_DIV_SCALE: begin
            div_num_in = mino_pkg::DIV_W'(mul_acc_ff);
            div_rem_in = '0;
            div_den_in = sum_mag;
            div_cnt_in = mino_pkg::DIV_STEPS;
         end
         mino_pkg::CMD_SCALE_SAVE: begin
            scale_in = (|div_num_ff[mino_pkg::DIV_W-1:32]) ? 32'hFFFF_FFFF
                                                           : div_num_ff[31:0];
         end
         mino_pkg::CMD_OUT_STATS: begin
            o_pix_in   = '0;
            o_mean_in  = n_zero ? '0 : mean_ff;
            o_sd_in    = n_zero ? '0 : sd_ff;
            o_min_in   = min_ff;
            o_max_in   = max_ff;
            o_cnt_in   = count_ff;
            o_empty_in = empty;
            o_stats_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         normal_ff    <= 24'd12800;
         add_const_ff <= 16'd256;
         cut_ff       <= 1'b0;
         byte_ff      <= 1'b0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         count_ff     <= '0;
         min_ff       <= 16'hFFFF;
         max_ff       <= 16'h0000;
         scale_ff     <= 32'h0001_0000;
         mul_plier_ff <= '0;
         div_cnt_ff   <= '0;
         sq_bit_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               mino_pkg::CSR_PIXEL_OFFSET: offset_ff    <= $signed(csr_wdata[16:0]);
               mino_pkg::CSR_NORMAL_VALUE: normal_ff    <= csr_wdata;
               mino_pkg::CSR_ADD_CONST:    add_const_ff <= csr_wdata[15:0];
               mino_pkg::CSR_CUT_OUTSIDE:  cut_ff       <= csr_wdata[0];
               mino_pkg::CSR_BYTE_PIXELS:  byte_ff      <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         scale_ff     <= scale_in;
         mul_plier_ff <= mul_plier_in;
         div_cnt_ff   <= div_cnt_in;
         sq_bit_ff    <= sq_bit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         func_ff <= req_func;
         pix_ff  <= req_pixel_in;
         mask_ff <= req_mask_byte;
      end
      acc_en_ff   <= acc_en_in;
      accp_ff     <= accp_in;
      accv_ff     <= accv_in;
      accsq_ff    <= accsq_in;
      prod_ff     <= prod_in;
      hold_ff     <= hold_in;
      mul_acc_ff  <= mul_acc_in;
      mul_cand_ff <= mul_cand_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      sq_v_ff     <= sq_v_in;
      sq_res_ff   <= sq_res_in;
      mean_ff     <= mean_in;
      sd_ff       <= sd_in;
      o_pix_ff    <= o_pix_in;
      o_mean_ff   <= o_mean_in;
      o_sd_ff     <= o_sd_in;
      o_min_ff    <= o_min_in;
      o_max_ff    <= o_max_in;
      o_cnt_ff    <= o_cnt_in;
      o_empty_ff  <= o_empty_in;
      o_stats_ff  <= o_stats_in;
   end

   assign status.func      = mino_pkg::func_type'(func_ff);
   assign status.n_zero    = n_zero;
   assign status.empty     = empty;
   assign status.mul_done  = (mul_plier_ff == '0);
   assign status.div_done  = (div_cnt_ff == '0);
   assign status.sqrt_done = (sq_bit_ff == '0);

   assign rsp_pixel_out   = o_pix_ff;
   assign rsp_mean_out    = o_mean_ff;
   assign rsp_sd_out      = o_sd_ff;
   assign rsp_min_out     = o_min_ff;
   assign rsp_max_out     = o_max_ff;
   assign rsp_pixel_count = o_cnt_ff;
   assign rsp_empty_flag  = o_empty_ff;
   assign rsp_is_stats    = o_stats_ff;

endmodule

@@ design/mino_ctrl.sv @@
module mino_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mino_pkg::dp_status_type status,
   output mino_pkg::dp_cmd_type    ctl
);

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_DECODE = 16'h0002,
      ST_ACC    = 16'h0004,
      ST_XOUT   = 16'h0008,
      ST_MULA   = 16'h0010,
      ST_MULB   = 16'h0020,
      ST_DIV1   = 16'h0040,
      ST_DIV2   = 16'h0080,
      ST_SQRT   = 16'h0100,
      ST_DIVM   = 16'h0200,
      ST_SCL    = 16'h0400,
      ST_MULS   = 16'h0800,
      ST_DIVS   = 16'h1000,
      ST_SOUT   = 16'h2000,
      ST_SSAVE  = 16'h4000,
      ST_SPARE  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      out_load;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      ctl.cmd   = mino_pkg::CMD_NONE;
      ctl.latch = req_valid && req_ready;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.func)
               mino_pkg::FUNC_CLEAR: begin
                  ctl.cmd  = mino_pkg::CMD_CLEAR;
                  state_in = ST_IDLE;
               end
               mino_pkg::FUNC_ACCUM: begin
                  ctl.cmd  = mino_pkg::CMD_ACC_PREP;
                  state_in = ST_ACC;
               end
               mino_pkg::FUNC_FINAL: begin
                  if (status.n_zero) begin
                     state_in = ST_SOUT;
                  end else begin
                     ctl.cmd  = mino_pkg::CMD_MUL_NSQ;
                     state_in = ST_MULA;
                  end
               end
               default: begin
                  ctl.cmd  = mino_pkg::CMD_XPROD;
                  state_in = ST_XOUT;
               end
            endcase
         end
         ST_ACC: begin
            ctl.cmd  = mino_pkg::CMD_ACC_ADD;
            state_in = ST_IDLE;
         end
         ST_XOUT: begin
            if (slot_free) begin
               ctl.cmd  = mino_pkg::CMD_OUT_XFORM;
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MULA: begin
            if (status.mul_done) begin
               ctl.cmd  = mino_pkg::CMD_MUL_MAG;
               state_in = ST_MULB;
            end
         end
         ST_MULB: begin
            if (status.mul_done) begin
               ctl.cmd  = mino_pkg::CMD_DIV_VAR;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (status.div_done) begin
               ctl.cmd  = mino_pkg::CMD_DIV_AGAIN;
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (status.div_done) begin
               ctl.cmd  = mino_pkg::CMD_SQRT;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (status.sqrt_done) begin
               ctl.cmd  = mino_pkg::CMD_DIV_MEAN;
               state_in = ST_DIVM;
            end
         end
         ST_DIVM: begin
            if (status.div_done) begin
               ctl.cmd  = mino_pkg::CMD_MEAN_SAVE;
               state_in = status.empty ? ST_SOUT : ST_SCL;
            end
         end
         ST_SCL: begin
            ctl.cmd  = mino_pkg::CMD_MUL_SCALE;
            state_in = ST_MULS;
         end
         ST_MULS: begin
            if (status.mul_done) begin
               ctl.cmd  = mino_pkg::CMD_DIV_SCALE;
               state_in = ST_DIVS;
            end
         end
         ST_DIVS: begin
            if (status.div_done) state_in = ST_SSAVE;
         end
         ST_SSAVE: begin
            ctl.cmd  = mino_pkg::CMD_SCALE_SAVE;
            state_in = ST_SOUT;
         end
         ST_SOUT: begin
            if (slot_free) begin
               ctl.cmd  = mino_pkg::CMD_OUT_STATS;
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/masked_intensity_normalizer.sv @@
// Masked intensity normalizer.
// Input channel (req_*): one item carries func, pixel_in and mask_byte.
//   func clear and accumulate give no result; finalize and transform give one.
// Result channel (rsp_*): one registered result item; is_stats marks a finalize.
// Config (csr_*): write-only registers; the user must write them only while
//   the block is idle, which the block itself does not enforce.
// Items are processed one at a time; req_ready is high only when idle.
//   A finalize with pixels counted runs two multiplies, two divides, the square
//   root and the mean divide, plus a multiply and a divide when a scale factor
//   is computed. The cost is set by the shared bit-serial divider (105 steps),
//   shift-add multiplier and square root unit.
// A new item is taken while the previous result still waits in the output
// register; an item that makes a result waits in its last step until the slot
// frees, so a stalled receiver holds off further input.
// Reset clears the statistics, sets the scale to 1.0 and loads register defaults.
module masked_intensity_normalizer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic [15:0]         req_pixel_in,
   input  logic [7:0]          req_mask_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_pixel_out,
   output logic signed [25:0]  rsp_mean_out,
   output logic [24:0]         rsp_sd_out,
   output logic [15:0]         rsp_min_out,
   output logic [15:0]         rsp_max_out,
   output logic [24:0]         rsp_pixel_count,
   output logic                rsp_empty_flag,
   output logic                rsp_is_stats,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_wdata
);

   mino_pkg::dp_cmd_type    ctl;
   mino_pkg::dp_status_type status;

   // sequencer: handshakes and step order
   mino_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctl       (ctl)
   );

   // statistics, arithmetic units, config and output register
   mino_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .status          (status),
      .req_func        (req_func),
      .req_pixel_in    (req_pixel_in),
      .req_mask_byte   (req_mask_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_mean_out    (rsp_mean_out),
      .rsp_sd_out      (rsp_sd_out),
      .rsp_min_out     (rsp_min_out),
      .rsp_max_out     (rsp_max_out),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_empty_flag  (rsp_empty_flag),
      .rsp_is_stats    (rsp_is_stats)
   );

   // transform results carry no statistics
   a_xform_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_stats |-> rsp_mean_out == 26'sd0 && rsp_sd_out == 25'd0)
      else $error("transform result carries statistics");

   // no pixels seen means the empty flag is up
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_stats && rsp_pixel_count == 25'd0 |-> rsp_empty_flag)
      else $error("empty statistics without empty flag");

   // an accepted item keeps req_ready low in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted back to back");

endmodule
